// ----- design/chct_pkg.sv -----
// Package for the complementary hue color transform.
// Holds the fixed-point constants, the divider stage record, the value tables and
// the channel scaling function. It depends on nothing else.
package chct_pkg;

  localparam int CH_W = 8;
  localparam int Q_W = 17;
  localparam int S_W = 16;
  localparam int H_W = 19;
  localparam int DVD_W = 27;

  localparam int FULL_SCALE = 252;
  localparam int ONE_Q16 = 65536;
  localparam int DEG45 = 46080;
  localparam int DEG60 = 61440;
  localparam int DEG90 = 92160;
  localparam int DEG120 = 122880;
  localparam int DEG180 = 184320;
  localparam int DEG240 = 245760;
  localparam int DEG270 = 276480;
  localparam int DEG300 = 307200;
  localparam int DEG360 = 368640;

  localparam int HUE_STEPS = 19;
  localparam int SAT_STEPS = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = 5;
  localparam int BACK_STAGES = 6;

  localparam int VMODE_PLAIN = 0;
  localparam int VMODE_BRIGHT = 1;
  localparam int VMODE_DARK = 2;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // One item in flight through the dividers: hue and saturation run side by side.
  typedef struct packed {
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] d;
    logic [CH_W-1:0] hue_rem;
    logic [H_W-1:0]  hue_q;
    logic [CH_W-1:0] sat_rem;
    logic [S_W-1:0]  sat_q;
  } div_t;

  typedef logic [Q_W-1:0] vtab_t [256];

  function automatic vtab_t build_vtab(int mode);
    vtab_t tab;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i * ONE_Q16) / FULL_SCALE;
      if (mode == VMODE_BRIGHT) begin
        v = (v * 6) / 5;
        if (v > ONE_Q16) v = ONE_Q16;
      end else if (mode == VMODE_DARK) begin
        v = (v * 3) / 5;
      end
      tab[i] = Q_W'(v);
    end
    return tab;
  endfunction

  localparam vtab_t V_PLAIN = build_vtab(VMODE_PLAIN);
  localparam vtab_t V_BRIGHT = build_vtab(VMODE_BRIGHT);
  localparam vtab_t V_DARK = build_vtab(VMODE_DARK);

  // Q1.16 level to an 8-bit channel with 252 as full scale, saturating at 255.
  function automatic logic [CH_W-1:0] to_ch(logic [Q_W-1:0] q);
    logic [Q_W+CH_W-1:0] p;
    p = (Q_W+CH_W)'(q) * (Q_W+CH_W)'(FULL_SCALE);
    return (p[Q_W+CH_W-1:16] > 9'd255) ? 8'hFF : p[23:16];
  endfunction

endpackage

// ----- design/chct_if.sv -----
// Channel interfaces for the complementary hue color transform.
// Each carries valid, ready and one color entry; uses chct_pkg for widths.
interface chct_in_if;
  import chct_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface chct_out_if;
  import chct_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  modport source(output valid, output red_out, output green_out, output blue_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ----- design/chct_front.sv -----
// Input stage: max, min, chroma and the hue and saturation dividends.
// Uses chct_pkg and the chct_in_if channel.
module chct_front (
  input  logic          clk,
  input  logic          rst,
  chct_in_if.sink       in_ch,
  output logic          out_valid,
  input  logic          out_ready,
  output chct_pkg::div_t out_data
);
  import chct_pkg::*;

  logic [CH_W-1:0]  r, g, b, mx, mn, d;
  logic [10:0]      num;
  logic [DVD_W-1:0] dvd;
  div_t             nxt;

  assign r = in_ch.red_in;
  assign g = in_ch.green_in;
  assign b = in_ch.blue_in;

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // Red wins ties for the maximum, then green.
    if (mx == r) begin
      num = {3'b0, d} * 11'd6 + {3'b0, g} - {3'b0, b};
    end else if (mx == g) begin
      num = {3'b0, d} * 11'd2 + {3'b0, b} - {3'b0, r};
    end else begin
      num = {3'b0, d} * 11'd4 + {3'b0, r} - {3'b0, g};
    end
    dvd = {16'b0, num} * DVD_W'(DEG60);
    // The quotient fits in 19 bits, so the top bits already sit below the divisor.
    nxt.mx = mx;
    nxt.d = d;
    nxt.hue_rem = dvd[DVD_W-1:H_W];
    nxt.hue_q = dvd[H_W-1:0];
    nxt.sat_rem = d;
    nxt.sat_q = '0;
  end

  assign in_ch.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      out_data <= nxt;
    end
  end

endmodule

// ----- design/chct_divider.sv -----
// Pipelined restoring dividers for hue and saturation, a few quotient bits per stage.
// Uses chct_pkg.
module chct_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  chct_pkg::div_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output chct_pkg::div_t out_data
);
  import chct_pkg::*;

  div_t stage [DIV_STAGES];
  logic vld [DIV_STAGES];
  logic adv [DIV_STAGES];

  assign adv[DIV_STAGES-1] = !vld[DIV_STAGES-1] || out_ready;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int HUE_LEFT = HUE_STEPS - i * STEPS_PER_STAGE;
    localparam int SAT_LEFT = SAT_STEPS - i * STEPS_PER_STAGE;
    localparam int HS = (HUE_LEFT < STEPS_PER_STAGE) ? HUE_LEFT : STEPS_PER_STAGE;
    localparam int SS = (SAT_LEFT <= 0) ? 0 :
                        ((SAT_LEFT < STEPS_PER_STAGE) ? SAT_LEFT : STEPS_PER_STAGE);
    div_t src;
    div_t nxt;

    if (i == 0) begin : g_first
      assign src = in_data;
    end else begin : g_next
      assign src = stage[i-1];
      assign adv[i-1] = !vld[i-1] || adv[i];
    end

    always_comb begin
      logic [CH_W:0] t;
      logic          ge;
      logic [CH_W:0] ts;
      logic          gs;
      nxt = src;
      for (int j = 0; j < HS; j++) begin
        t = {nxt.hue_rem, nxt.hue_q[H_W-1]};
        ge = t >= {1'b0, nxt.d};
        nxt.hue_q = {nxt.hue_q[H_W-2:0], ge};
        nxt.hue_rem = ge ? CH_W'(t - {1'b0, nxt.d}) : t[CH_W-1:0];
      end
      for (int j = 0; j < SS; j++) begin
        ts = {nxt.sat_rem, nxt.sat_q[S_W-1]};
        gs = ts >= {1'b0, nxt.mx};
        nxt.sat_q = {nxt.sat_q[S_W-2:0], gs};
        nxt.sat_rem = gs ? CH_W'(ts - {1'b0, nxt.mx}) : ts[CH_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv[i]) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        stage[i] <= nxt;
      end
    end
  end

  assign in_ready = adv[0];
  assign out_valid = vld[DIV_STAGES-1];
  assign out_data = stage[DIV_STAGES-1];

endmodule

// ----- design/chct_back.sv -----
// Back end: hue rotation, value adjust, chroma, sector blend and channel scaling.
// Uses chct_pkg and drives the chct_out_if channel.
module chct_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  chct_pkg::div_t in_data,
  chct_out_if.source     out_ch
);
  import chct_pkg::*;

  logic vld [BACK_STAGES];
  logic adv [BACK_STAGES];

  logic [H_W-1:0] h0, hr;
  logic [H_W:0]   hsum;
  logic [Q_W-1:0] s0;
  logic [Q_W-1:0] v0;

  logic [H_W-1:0] p1_h;
  logic [Q_W-1:0] p1_s;
  logic [Q_W-1:0] p1_v;

  logic [2*Q_W-2:0] vs_prod;
  sector_t          sec;
  logic [Q_W-1:0]   seg;
  logic [S_W-1:0]   f;

  logic [Q_W-1:0] p2_c, p2_v;
  logic [S_W-1:0] p2_f;
  sector_t        p2_sec;

  logic [2*Q_W-2:0] cf_prod;

  logic [20:0]    p3_y;
  logic [Q_W-1:0] p3_c, p3_m;
  sector_t        p3_sec;

  logic [41:0]    ya;
  logic [41:0]    p4_a, p4_b;
  logic [Q_W-1:0] p4_c, p4_m;
  sector_t        p4_sec;

  logic [41:0]    sm;
  logic [Q_W-1:0] p5_x, p5_c, p5_m;
  sector_t        p5_sec;

  logic [Q_W-1:0] nr, ng, nb;

  assign adv[BACK_STAGES-1] = !vld[BACK_STAGES-1] || out_ch.ready;
  for (genvar i = 0; i < BACK_STAGES - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BACK_STAGES; i++) vld[i] <= 1'b0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < BACK_STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready = adv[0];
  assign out_ch.valid = vld[BACK_STAGES-1];

  // Stage 1: wrap the red hue, handle gray, rotate and pick the value level.
  always_comb begin
    h0 = in_data.hue_q;
    if (h0 >= H_W'(DEG360)) h0 = h0 - H_W'(DEG360);
    // With a zero channel the chroma equals the maximum and saturation is exactly one,
    // which the 16-bit quotient cannot hold.
    s0 = (in_data.d == in_data.mx) ? Q_W'(ONE_Q16) : {1'b0, in_data.sat_q};
    // A gray entry has no hue and no saturation.
    if (in_data.d == '0) begin
      h0 = '0;
      s0 = '0;
    end
    hsum = {1'b0, h0} + (H_W+1)'(DEG180);
    hr = (hsum >= (H_W+1)'(DEG360)) ? H_W'(hsum - (H_W+1)'(DEG360)) : hsum[H_W-1:0];
    if (hr >= H_W'(DEG180) && hr < H_W'(DEG270)) begin
      v0 = V_BRIGHT[in_data.mx];
    end else if (hr >= H_W'(DEG45) && hr < H_W'(DEG90)) begin
      v0 = V_DARK[in_data.mx];
    end else begin
      v0 = V_PLAIN[in_data.mx];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1_h <= hr;
      p1_s <= s0;
      p1_v <= v0;
    end
  end

  // Stage 2: chroma, sector and distance from the nearest primary.
  always_comb begin
    vs_prod = (2*Q_W-1)'(p1_v) * (2*Q_W-1)'(p1_s);
    if (p1_h < H_W'(DEG60)) sec = SEC_RY;
    else if (p1_h < H_W'(DEG120)) sec = SEC_YG;
    else if (p1_h < H_W'(DEG180)) sec = SEC_GC;
    else if (p1_h < H_W'(DEG240)) sec = SEC_CB;
    else if (p1_h < H_W'(DEG300)) sec = SEC_BM;
    else sec = SEC_MR;
    case (sec) inside
      SEC_RY, SEC_YG: seg = Q_W'(p1_h);
      SEC_GC, SEC_CB: seg = Q_W'(p1_h - H_W'(DEG120));
      default:        seg = Q_W'(p1_h - H_W'(DEG240));
    endcase
    f = (seg < Q_W'(DEG60)) ? seg[S_W-1:0] : S_W'(Q_W'(DEG120) - seg);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p2_c <= vs_prod[2*Q_W-2:16];
      p2_v <= p1_v;
      p2_f <= f;
      p2_sec <= sec;
    end
  end

  // Stage 3: chroma times distance, pre-divided by 4096; the rest is a divide by 15.
  assign cf_prod = (2*Q_W-1)'(p2_c) * (2*Q_W-1)'(p2_f);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p3_y <= cf_prod[2*Q_W-2:12];
      p3_c <= p2_c;
      p3_m <= p2_v - p2_c;
      p3_sec <= p2_sec;
    end
  end

  // Stages 4 and 5: multiply by 0x111112 and drop 24 bits, which is exact
  // for every value that reaches here.
  assign ya = 42'(p3_y);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p4_a <= (ya << 20) + (ya << 16) + (ya << 12);
      p4_b <= (ya << 8) + (ya << 4) + (ya << 1);
      p4_c <= p3_c;
      p4_m <= p3_m;
      p4_sec <= p3_sec;
    end
  end

  assign sm = p4_a + p4_b;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      p5_x <= sm[40:24];
      p5_c <= p4_c;
      p5_m <= p4_m;
      p5_sec <= p4_sec;
    end
  end

  // Stage 6: place chroma and the blend term by sector, add the floor, scale out.
  always_comb begin
    case (p5_sec)
      SEC_RY:  begin nr = p5_c; ng = p5_x; nb = '0;   end
      SEC_YG:  begin nr = p5_x; ng = p5_c; nb = '0;   end
      SEC_GC:  begin nr = '0;   ng = p5_c; nb = p5_x; end
      SEC_CB:  begin nr = '0;   ng = p5_x; nb = p5_c; end
      SEC_BM:  begin nr = p5_x; ng = '0;   nb = p5_c; end
      default: begin nr = p5_c; ng = '0;   nb = p5_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      out_ch.red_out <= to_ch(nr + p5_m);
      out_ch.green_out <= to_ch(ng + p5_m);
      out_ch.blue_out <= to_ch(nb + p5_m);
    end
  end

endmodule

// ----- design/complementary_hue_color_transform_core.sv -----
// Top level of the complementary hue color transform.
// Chains chct_front, chct_divider and chct_back; uses chct_pkg and chct_if.
//
//   channel  direction  carries
//   in_ch    sink       red_in, green_in, blue_in (252 is full scale)
//   out_ch   source     red_out, green_out, blue_out of the complementary color
//
// One entry enters per cycle unless the output stalls. The divider stage
// count is set by the 19-bit hue quotient, up to four bits per stage.
// Reset clears all valid bits; no data register is reset.
// Every stage holds while the one after it is full and stalled, so a stall
// backs up stage by stage and empty stages still fill behind it.
module complementary_hue_color_transform_core (
  input  logic        clk,
  input  logic        rst,
  chct_in_if.sink     in_ch,
  chct_out_if.source  out_ch
);
  import chct_pkg::*;

  logic front_valid, front_ready;
  div_t front_data;
  logic div_valid, div_ready;
  div_t div_data;

  chct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_valid(front_valid),
    .out_ready(front_ready),
    .out_data (front_data)
  );

  chct_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_data  (front_data),
    .out_valid(div_valid),
    .out_ready(div_ready),
    .out_data (div_data)
  );

  chct_back u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(div_valid),
    .in_ready(div_ready),
    .in_data (div_data),
    .out_ch  (out_ch)
  );

endmodule

// ----- design/chct_checker.sv -----
// Port-level checks for the complementary hue color transform.
// Bound to complementary_hue_color_transform_core; uses chct_pkg for widths.
module chct_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [chct_pkg::CH_W-1:0] red_out,
  input logic [chct_pkg::CH_W-1:0] green_out,
  input logic [chct_pkg::CH_W-1:0] blue_out
);
  import chct_pkg::*;

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // A taken result frees the whole pipe, so the input must be open.
  a_flow: assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input blocked while the output transfer completes");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
    else $error("result changed while stalled");

endmodule

bind complementary_hue_color_transform_core chct_checker u_chct_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .red_out  (out_ch.red_out),
  .green_out(out_ch.green_out),
  .blue_out (out_ch.blue_out)
);
